// ===== hdl/smfa_pkg.sv =====
// Shared opcodes and widths for the sign-magnitude fraction ALU.
package smfa_pkg;
   localparam int MAG_BITS_DEFAULT = 30;
   localparam int OP_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_AND = 3'd4
   } op_type;
endpackage

// ===== hdl/smfa_div_stage.sv =====
// One step of the pipelined restoring fraction divider.
module smfa_div_stage #(
   parameter int MAG_BITS = smfa_pkg::MAG_BITS_DEFAULT
) (
   input  logic [MAG_BITS-1:0] divisor,
   input  logic [MAG_BITS-1:0] rem_cur,
   input  logic [MAG_BITS-1:0] quo_cur,
   output logic [MAG_BITS-1:0] rem_next,
   output logic [MAG_BITS-1:0] quo_next
);
   import smfa_pkg::*;

   logic [MAG_BITS:0] shifted;
   logic [MAG_BITS:0] diff;

   always_comb begin
      shifted = {rem_cur, 1'b0};
      diff = shifted - {1'b0, divisor};
      if (shifted >= {1'b0, divisor}) begin
         rem_next = diff[MAG_BITS-1:0];
         quo_next = {quo_cur[MAG_BITS-2:0], 1'b1};
      end else begin
         rem_next = shifted[MAG_BITS-1:0];
         quo_next = {quo_cur[MAG_BITS-2:0], 1'b0};
      end
   end
endmodule

// ===== hdl/sign_magnitude_fraction_alu.sv =====
// Top level: pipelined sign-magnitude fraction ALU.
//
//  channel | ports                               | direction
//  req     | req_valid, req_stall, req_* fields  | in
//  rsp     | rsp_valid, rsp_stall, rsp_* fields  | out
//
// The pipe has one operand stage, one divider step per stage over MAG_BITS
// stages, and one result stage. A transaction can enter every cycle unless
// req_stall is high. The whole pipe advances when the output register is free or
// being taken; otherwise it freezes, so nothing is lost or repeated.
// Reset clears the valid bits only.
module sign_magnitude_fraction_alu #(
   parameter int MAG_BITS = smfa_pkg::MAG_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [smfa_pkg::OP_BITS-1:0]  req_opcode,
   input  logic                          req_a_negative,
   input  logic [MAG_BITS-1:0]           req_a_magnitude,
   input  logic                          req_b_negative,
   input  logic [MAG_BITS-1:0]           req_b_magnitude,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [MAG_BITS:0]             rsp_result_word,
   output logic                          rsp_overflow
);
   import smfa_pkg::*;

   localparam int DEPTH = MAG_BITS;

   typedef struct packed {
      logic [MAG_BITS:0] word;
      logic              ovf;
      logic              is_div;
      logic              is_mul;
      logic              sign;
   } carry_type;

   logic advance;
   assign advance = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Stage 0: operands, add/sub/and results, product
   logic              v0_ff;
   carry_type         c0_ff;
   carry_type         c0_in;
   logic [MAG_BITS-1:0] a0_ff, b0_ff;
   logic [MAG_BITS-1:0] prod0_ff;
   logic [2*MAG_BITS-1:0] prod0_in;

   logic              eff_an;
   logic [MAG_BITS:0] mag;
   logic              neg;

   assign prod0_in = {{MAG_BITS{1'b0}}, req_a_magnitude} *
                     {{MAG_BITS{1'b0}}, req_b_magnitude};

   always_comb begin
      eff_an = req_a_negative ^ (op_type'(req_opcode) == OP_SUB);
      if (eff_an == req_b_negative) begin
         mag = {1'b0, req_a_magnitude} + {1'b0, req_b_magnitude};
         neg = req_b_negative;
      end else if (req_b_magnitude >= req_a_magnitude) begin
         mag = {1'b0, req_b_magnitude} - {1'b0, req_a_magnitude};
         neg = req_b_negative;
      end else begin
         mag = {1'b0, req_a_magnitude} - {1'b0, req_b_magnitude};
         neg = eff_an;
      end
      c0_in = '0;
      c0_in.sign = req_a_negative ^ req_b_negative;
      case (op_type'(req_opcode))
         OP_ADD, OP_SUB: begin
            if (mag[MAG_BITS]) begin
               c0_in.ovf = 1'b1;
            end else begin
               c0_in.word = {neg, mag[MAG_BITS-1:0]};
            end
         end
         OP_MUL: c0_in.is_mul = 1'b1;
         OP_DIV: begin
            if (req_b_magnitude >= req_a_magnitude) begin
               c0_in.ovf = 1'b1;
            end else begin
               c0_in.is_div = 1'b1;
            end
         end
         OP_AND: c0_in.word = {req_b_negative, req_a_magnitude & req_b_magnitude};
         default: c0_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
      if (advance) begin
         c0_ff <= c0_in;
         a0_ff <= req_a_magnitude;
         b0_ff <= req_b_magnitude;
         prod0_ff <= prod0_in[2*MAG_BITS-1:MAG_BITS];
      end
   end

   // Divider stages; product rides along in the pipe
   logic [DEPTH:0]      v_ff;
   carry_type           c_ff   [DEPTH+1];
   logic [MAG_BITS-1:0] dvs_ff [DEPTH+1];
   logic [MAG_BITS-1:0] rem_ff [DEPTH+1];
   logic [MAG_BITS-1:0] quo_ff [DEPTH+1];
   logic [MAG_BITS-1:0] prd_ff [DEPTH+1];

   assign v_ff[0]   = v0_ff;
   assign c_ff[0]   = c0_ff;
   assign dvs_ff[0] = a0_ff;
   assign rem_ff[0] = b0_ff;
   assign quo_ff[0] = '0;
   assign prd_ff[0] = prod0_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_div
      logic [MAG_BITS-1:0] rem_in, quo_in;
      logic                vs_ff;
      carry_type           cs_ff;
      logic [MAG_BITS-1:0] ds_ff, rs_ff, qs_ff, ps_ff;

      smfa_div_stage #(.MAG_BITS(MAG_BITS)) u_step (
         .divisor (dvs_ff[i]),
         .rem_cur (rem_ff[i]),
         .quo_cur (quo_ff[i]),
         .rem_next(rem_in),
         .quo_next(quo_in)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            vs_ff <= 1'b0;
         end else if (advance) begin
            vs_ff <= v_ff[i];
         end
         if (advance) begin
            cs_ff <= c_ff[i];
            ds_ff <= dvs_ff[i];
            rs_ff <= rem_in;
            qs_ff <= quo_in;
            ps_ff <= prd_ff[i];
         end
      end

      assign v_ff[i+1]   = vs_ff;
      assign c_ff[i+1]   = cs_ff;
      assign dvs_ff[i+1] = ds_ff;
      assign rem_ff[i+1] = rs_ff;
      assign quo_ff[i+1] = qs_ff;
      assign prd_ff[i+1] = ps_ff;
   end

   // Output register
   logic              rv_ff;
   logic [MAG_BITS:0] rw_ff, rw_in;
   logic              ro_ff;

   always_comb begin
      if (c_ff[DEPTH].is_div) begin
         rw_in = {c_ff[DEPTH].sign, quo_ff[DEPTH]};
      end else if (c_ff[DEPTH].is_mul) begin
         rw_in = {c_ff[DEPTH].sign, prd_ff[DEPTH]};
      end else begin
         rw_in = c_ff[DEPTH].word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (advance) begin
         rv_ff <= v_ff[DEPTH];
      end
      if (advance) begin
         rw_ff <= rw_in;
         ro_ff <= c_ff[DEPTH].ovf;
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_result_word = rw_ff;
   assign rsp_overflow    = ro_ff;
endmodule

// ===== tb/sign_magnitude_fraction_alu_tb.sv =====
// Self-checking testbench for the sign-magnitude fraction ALU.
module sign_magnitude_fraction_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smfa_pkg::*;

   localparam int MB = MAG_BITS_DEFAULT;
   localparam logic [MB-1:0] MAG_MAX = '1;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [MB:0] word;
      logic        ovf;
   } alu_result_type;

   class alu_scoreboard;
      alu_result_type pending[$];
      int errors = 0;

      function automatic alu_result_type compute(logic [2:0] op, logic an, logic [MB-1:0] am,
                                                 logic bn, logic [MB-1:0] bm);
         alu_result_type r;
         logic [MB:0] mag;
         logic neg, ean;
         logic [2*MB-1:0] prod;
         logic [2*MB-1:0] quo;
         r = '0;
         ean = an;
         case (op)
            OP_ADD, OP_SUB: begin
               if (op == OP_SUB) ean = ~an;
               if (ean == bn) begin
                  mag = {1'b0, am} + {1'b0, bm};
                  neg = bn;
               end else if (bm >= am) begin
                  mag = {1'b0, bm - am};
                  neg = bn;
               end else begin
                  mag = {1'b0, am - bm};
                  neg = ean;
               end
               if (mag[MB]) r.ovf = 1'b1;
               else r.word = {neg, mag[MB-1:0]};
            end
            OP_MUL: begin
               prod = {{MB{1'b0}}, am} * {{MB{1'b0}}, bm};
               r.word = {an ^ bn, prod[2*MB-1:MB]};
            end
            OP_DIV: begin
               if (bm >= am) r.ovf = 1'b1;
               else begin
                  quo = {bm, {MB{1'b0}}} / {{MB{1'b0}}, am};
                  r.word = {an ^ bn, quo[MB-1:0]};
               end
            end
            OP_AND: r.word = {bn, am & bm};
            default: r = '0;
         endcase
         return r;
      endfunction

      function void note_operation(logic [2:0] op, logic an, logic [MB-1:0] am,
                                   logic bn, logic [MB-1:0] bm);
         pending.push_back(compute(op, an, am, bn, bm));
      endfunction

      function void check_result(logic [MB:0] word, logic ovf);
         alu_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected transaction: word=%h overflow=%b", word, ovf);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (word !== e.word) begin
            $error("result_word: expected %h, actual %h", e.word, word);
            errors++;
         end
         if (ovf !== e.ovf) begin
            $error("overflow: expected %b, actual %b", e.ovf, ovf);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall;
   logic [OP_BITS-1:0] req_opcode = '0;
   logic req_a_negative = 0, req_b_negative = 0;
   logic [MB-1:0] req_a_magnitude = '0, req_b_magnitude = '0;
   logic rsp_valid, rsp_stall = 0, rsp_overflow;
   logic [MB:0] rsp_result_word;
   logic stim_done = 0;
   int cycles = 0;
   alu_scoreboard sb = new();

   sign_magnitude_fraction_alu DUT (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && !req_stall)
         sb.note_operation(req_opcode, req_a_negative, req_a_magnitude,
                           req_b_negative, req_b_magnitude);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_word, rsp_overflow);
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stall stretches, with quiet stretches of none
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if ($urandom_range(0, 1)) gap = 0;
         repeat (gap) begin
            rsp_stall <= 1;
            @(negedge clock);
         end
         rsp_stall <= 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   function automatic logic [MB-1:0] rand_mag();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return MAG_MAX;
         2: return MB'($urandom_range(0, 15));
         default: return MB'({$urandom, $urandom});
      endcase
   endfunction

   // one transaction; waits out a random gap first when idle is set
   task automatic send_op(logic [2:0] op, logic an, logic [MB-1:0] am,
                          logic bn, logic [MB-1:0] bm, bit idle);
      if (idle) begin
         repeat ($urandom_range(0, 18)) begin
            req_valid <= 0;
            @(negedge clock);
         end
      end
      req_valid <= 1;
      req_opcode <= op;
      req_a_negative <= an;
      req_a_magnitude <= am;
      req_b_negative <= bn;
      req_b_magnitude <= bm;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [2:0] op;
      logic [MB-1:0] am, bm;
      bit idle_mode;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, every operation, zero results, minus zero, bad opcodes
      send_op(OP_ADD, 0, MAG_MAX, 0, MAG_MAX, 0);
      send_op(OP_ADD, 0, MB'(1), 0, MAG_MAX, 0);
      send_op(OP_ADD, 1, MB'(5), 0, MB'(5), 0);
      send_op(OP_ADD, 0, MB'(5), 1, MB'(5), 0);
      send_op(OP_ADD, 1, MB'(9), 0, MB'(3), 0);
      send_op(OP_SUB, 0, MB'(7), 1, MB'(7), 0);
      send_op(OP_SUB, 0, MB'(7), 0, MB'(7), 0);
      send_op(OP_SUB, 1, MAG_MAX, 0, MAG_MAX, 0);
      send_op(OP_SUB, 0, MAG_MAX, 0, '0, 0);
      send_op(OP_MUL, 0, MAG_MAX, 0, MAG_MAX, 0);
      send_op(OP_MUL, 1, '0, 0, MAG_MAX, 0);
      send_op(OP_MUL, 1, MAG_MAX, 1, MB'(1), 0);
      send_op(OP_DIV, 0, '0, 0, '0, 0);
      send_op(OP_DIV, 0, MB'(3), 1, MB'(3), 0);
      send_op(OP_DIV, 1, MAG_MAX, 0, MAG_MAX - MB'(1), 0);
      send_op(OP_DIV, 0, MAG_MAX, 1, '0, 0);
      send_op(OP_DIV, 1, MB'(1), 1, '0, 0);
      send_op(OP_AND, 0, MAG_MAX, 1, MAG_MAX, 0);
      send_op(OP_AND, 1, '0, 0, MAG_MAX, 0);
      for (int u = 5; u < 8; u++)
         send_op(3'(u), 1, MAG_MAX, 1, MAG_MAX, 0);
      // random, bursts of 100 with or without sender gaps, picked at random per burst
      for (int i = 0; i < 1350; i++) begin
         if (i % 100 == 0) idle_mode = 1'($urandom_range(0, 1));
         if (i == 600) begin
            req_valid <= 0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
         am = rand_mag();
         bm = rand_mag();
         // keep most divides in range so quotients get exercised
         if (op == OP_DIV && $urandom_range(0, 3) != 0 && bm >= am) begin
            am = bm | (MB'(1) << (MB - 1));
            if (bm >= am) bm = am - MB'(1);
         end
         send_op(op, 1'($urandom_range(0, 1)), am, 1'($urandom_range(0, 1)), bm,
                 idle_mode);
      end
      req_valid <= 0;
      stim_done <= 1;
   end

   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (MB + 40) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
